FILE: rtl/assert_macros.svh
// Assertion macros used by the RTL of the co-occurrence counter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// When cond holds, expr must hold at the same edge.
`define ASSERT_IMPL(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) else $error(msg);

// When cond holds, expr must hold at the next edge.
`define ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) else $error(msg);

`endif

FILE: rtl/pcc_pkg.sv
// Types and constants of the co-occurrence counter RTL.
`default_nettype none

package pcc_pkg;

	localparam int CLUSTER_W = 6;
	localparam int CFG_W     = 7;
	localparam int OUT_W     = 32;

	// Action codes of an input word.
	localparam logic ACT_NEW_CASE = 1'b0;
	localparam logic ACT_OBSERVE  = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_NOT_FOUND = 2'd1,
		STATUS_SEEN      = 2'd2
	} status_t;

	// Case epoch stored in the flag memory; zero is never a live epoch.
	localparam int EPOCH_W = 8;
	typedef logic [EPOCH_W-1:0] epoch_t;
	localparam epoch_t EPOCH_NONE  = epoch_t'(0);
	localparam epoch_t EPOCH_FIRST = epoch_t'(1);

endpackage

`default_nettype wire

FILE: rtl/pcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/pairwise_cooccurrence_counter_unit.sv
// Pair co-occurrence counter: a symmetric count matrix and per-case pair flags in RAM.
//
// Input channel (in_valid/in_ready) carries one word: action, first_cluster,
// second_cluster. Output channel (out_valid/out_ready) returns one word per input:
// status, pair_count, case_count. cfg_we writes cluster_count at any idle cycle.
// An observe word goes from S_IDLE through S_READ_BA, S_WRITE_AB, S_WRITE_BA and
// S_RESP (S_WRITE_BA is skipped when the pair was already seen in this case), and
// in_ready stays low until the unit is back in S_IDLE: the count and flag memories
// have one read port and one write port, so the two mirrored entries are read and
// written one after another. A new-case word that does not wrap the epoch, or an
// out-of-range pair, goes straight to S_RESP. A new case does not touch the flag
// memory; it advances an epoch tag, and once every 255 cases the tag wraps and the
// flag memory is swept, MAX_CLUSTERS rounded up to a power of two, squared, entries
// (4096 by default), one per cycle. After reset both memories are swept the same
// way before in_ready rises. The result sits in an output register; a stalled
// receiver holds it there, the next word is still accepted and processed, and it
// then waits to be loaded until the register is taken.
`default_nettype none
`include "assert_macros.svh"

module pairwise_cooccurrence_counter_unit
	import pcc_pkg::*;
#(
	parameter int MAX_CLUSTERS = 64,
	parameter int COUNT_WIDTH  = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 action,
	input  wire logic [CLUSTER_W-1:0] first_cluster,
	input  wire logic [CLUSTER_W-1:0] second_cluster,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [1:0]                status,
	output logic [OUT_W-1:0]          pair_count,
	output logic [OUT_W-1:0]          case_count
);

	localparam int IW    = $clog2(MAX_CLUSTERS);
	localparam int AW    = 2 * IW;
	localparam int DEPTH = 1 << AW;
	localparam int LIM_W = $clog2(MAX_CLUSTERS + 128);

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [AW-1:0]          addr_t;
	typedef logic [IW-1:0]          idx_t;
	typedef logic [LIM_W-1:0]       lim_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ_BA,
		S_WRITE_AB,
		S_WRITE_BA,
		S_RESP
	} state_t;

	function automatic count_t sat_inc(input count_t v);
		return (&v) ? v : v + count_t'(1);
	endfunction

	function automatic logic [OUT_W-1:0] to_out(input count_t v);
		logic [COUNT_WIDTH+OUT_W-1:0] w;
		w = {{OUT_W{1'b0}}, v};
		return w[OUT_W-1:0];
	endfunction

	state_t           state_q;
	addr_t            sweep_q;
	logic             clr_cnt_q;
	epoch_t           epoch_q;
	count_t           case_cnt_q;
	logic [CFG_W-1:0] cc_q;
	idx_t             a_q;
	idx_t             b_q;
	count_t           cnt_ab_q;
	count_t           cnt_ba_q;
	epoch_t           tag_ab_q;
	status_t          res_status_q;
	count_t           res_pair_q;
	logic             out_valid_q;
	status_t          status_q;
	logic [OUT_W-1:0] pair_q;
	logic [OUT_W-1:0] case_q;

	logic [IW+CLUSTER_W-1:0] a_wide;
	logic [IW+CLUSTER_W-1:0] b_wide;
	idx_t   a_idx;
	idx_t   b_idx;
	lim_t   cc_ext;
	lim_t   limit;
	logic   not_found;
	logic   diag;
	count_t inc_ba;

	addr_t  rd_addr;
	count_t cnt_rdata;
	epoch_t tag_rdata;
	logic   cnt_we;
	addr_t  cnt_waddr;
	count_t cnt_wdata;
	logic   tag_we;
	addr_t  tag_waddr;
	epoch_t tag_wdata;

	assign a_wide = {{IW{1'b0}}, first_cluster};
	assign b_wide = {{IW{1'b0}}, second_cluster};
	assign a_idx  = a_wide[IW-1:0];
	assign b_idx  = b_wide[IW-1:0];

	// A register value above the array size acts as the array size.
	assign cc_ext    = LIM_W'(cc_q);
	assign limit     = (cc_ext > LIM_W'(MAX_CLUSTERS)) ? LIM_W'(MAX_CLUSTERS) : cc_ext;
	assign not_found = (LIM_W'(first_cluster) >= limit) || (LIM_W'(second_cluster) >= limit);

	// On the diagonal both updates hit one entry, so it is bumped twice.
	assign diag   = (a_q == b_q);
	assign inc_ba = sat_inc(diag ? cnt_ab_q : cnt_ba_q);

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign pair_count = pair_q;
	assign case_count = case_q;

	always_comb begin
		rd_addr   = '0;
		cnt_we    = 1'b0;
		cnt_waddr = '0;
		cnt_wdata = '0;
		tag_we    = 1'b0;
		tag_waddr = '0;
		tag_wdata = EPOCH_NONE;
		case (state_q)
			S_CLEAR: begin
				cnt_we    = clr_cnt_q;
				cnt_waddr = sweep_q;
				tag_we    = 1'b1;
				tag_waddr = sweep_q;
			end
			S_IDLE: begin
				rd_addr = {a_idx, b_idx};
			end
			S_READ_BA: begin
				rd_addr = {b_q, a_q};
			end
			S_WRITE_AB: begin
				if (tag_ab_q != epoch_q) begin
					cnt_we    = 1'b1;
					cnt_waddr = {a_q, b_q};
					cnt_wdata = sat_inc(cnt_ab_q);
					tag_we    = 1'b1;
					tag_waddr = {a_q, b_q};
					tag_wdata = epoch_q;
				end
			end
			S_WRITE_BA: begin
				cnt_we    = 1'b1;
				cnt_waddr = {b_q, a_q};
				cnt_wdata = inc_ba;
				tag_we    = 1'b1;
				tag_waddr = {b_q, a_q};
				tag_wdata = epoch_q;
			end
			default: begin
			end
		endcase
	end

	pcc_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(DEPTH)
	) u_count_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(cnt_waddr),
		.wdata(cnt_wdata),
		.raddr(rd_addr),
		.rdata(cnt_rdata)
	);

	pcc_ram #(
		.WIDTH(EPOCH_W),
		.DEPTH(DEPTH)
	) u_flag_ram (
		.clk  (clk),
		.we   (tag_we),
		.waddr(tag_waddr),
		.wdata(tag_wdata),
		.raddr(rd_addr),
		.rdata(tag_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			sweep_q      <= '0;
			clr_cnt_q    <= 1'b1;
			epoch_q      <= EPOCH_FIRST;
			case_cnt_q   <= '0;
			cc_q         <= '0;
			a_q          <= '0;
			b_q          <= '0;
			cnt_ab_q     <= '0;
			cnt_ba_q     <= '0;
			tag_ab_q     <= EPOCH_NONE;
			res_status_q <= STATUS_OK;
			res_pair_q   <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= STATUS_OK;
			pair_q       <= '0;
			case_q       <= '0;
		end else begin
			if (cfg_we) begin
				cc_q <= cfg_wdata;
			end
			if (state_q == S_RESP && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					sweep_q <= sweep_q + addr_t'(1);
					if (&sweep_q) begin
						clr_cnt_q <= 1'b0;
						state_q   <= clr_cnt_q ? S_IDLE : S_RESP;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						a_q <= a_idx;
						b_q <= b_idx;
						res_pair_q <= '0;
						if (action == ACT_NEW_CASE) begin
							case_cnt_q   <= sat_inc(case_cnt_q);
							res_status_q <= STATUS_OK;
							// Epoch wrap: old tags could alias, so sweep them away.
							if (&epoch_q) begin
								epoch_q <= EPOCH_FIRST;
								state_q <= S_CLEAR;
							end else begin
								epoch_q <= epoch_q + EPOCH_FIRST;
								state_q <= S_RESP;
							end
						end else if (not_found) begin
							res_status_q <= STATUS_NOT_FOUND;
							state_q      <= S_RESP;
						end else begin
							state_q <= S_READ_BA;
						end
					end
				end
				S_READ_BA: begin
					cnt_ab_q <= cnt_rdata;
					tag_ab_q <= tag_rdata;
					state_q  <= S_WRITE_AB;
				end
				S_WRITE_AB: begin
					if (tag_ab_q == epoch_q) begin
						res_status_q <= STATUS_SEEN;
						res_pair_q   <= cnt_ab_q;
						state_q      <= S_RESP;
					end else begin
						cnt_ab_q <= sat_inc(cnt_ab_q);
						cnt_ba_q <= cnt_rdata;
						state_q  <= S_WRITE_BA;
					end
				end
				S_WRITE_BA: begin
					res_status_q <= STATUS_OK;
					res_pair_q   <= diag ? inc_ba : cnt_ab_q;
					state_q      <= S_RESP;
				end
				S_RESP: begin
					if (!out_valid_q || out_ready) begin
						status_q    <= res_status_q;
						pair_q      <= to_out(res_pair_q);
						case_q      <= to_out(case_cnt_q);
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ASSERT_ALWAYS(a_epoch_live, epoch_q != EPOCH_NONE, "epoch tag reached the cleared value")
	`ASSERT_NEXT(a_case_bump, in_valid && in_ready && action == ACT_NEW_CASE, (case_cnt_q != $past(case_cnt_q)) || (&case_cnt_q), "new case did not advance the case counter")
	`ASSERT_IMPL(a_pair_write, cnt_we && state_q != S_CLEAR, tag_we && tag_waddr == cnt_waddr && tag_wdata == epoch_q, "count update without matching flag update")

endmodule

`default_nettype wire
